// ----- rtl/core/pbd_pkg.sv -----
package pbd_pkg;

  localparam logic [31:0] SHB_MAGIC = 32'h0a0d0d0a;
  localparam logic [31:0] BO_MAGIC  = 32'h1a2b3c4d;
  localparam logic [31:0] BT_IDB    = 32'd1;
  localparam logic [31:0] BT_EPB    = 32'd6;
  localparam logic [15:0] LINK_BT   = 16'd201;
  localparam logic [15:0] OPT_TSRES = 16'd9;
  localparam logic [31:0] MIN_CAP   = 32'd14;

  localparam logic [1:0] KIND_DESC   = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_CAP   = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] interface_id;
    logic [15:0] link_type;
    logic [15:0] captured_length;
    logic [63:0] timestamp;
    logic [7:0]  time_resolution;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [2:0]  status;
    logic        bt_link;
  } item_t;

  typedef struct packed {
    logic  v0;
    logic  v1;
    item_t i0;
    item_t i1;
  } push_t;

  function automatic logic [31:0] swap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [31:0] rd32(input logic be, input logic [31:0] w);
    return be ? swap32(w) : w;
  endfunction

  function automatic logic [15:0] rd16lo(input logic be, input logic [31:0] w);
    return be ? {w[7:0], w[15:8]} : w[15:0];
  endfunction

  function automatic logic [15:0] rd16hi(input logic be, input logic [31:0] w);
    return be ? {w[23:16], w[31:24]} : w[31:16];
  endfunction

endpackage

// ----- rtl/core/pbd_parser.sv -----
module pbd_parser import pbd_pkg::*; #(
  parameter int MAX_BLOCK      = 65536,
  parameter int MAX_INTERFACES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] total_len_i,
  input  logic        acc_i,
  input  logic [7:0]  byte_i,
  output push_t       push_o
);

  localparam int IW = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
  localparam int CW = $clog2(MAX_INTERFACES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_INTERFACES);

  logic [15:0] link_mem [MAX_INTERFACES];
  logic [7:0]  res_mem  [MAX_INTERFACES];

  logic [31:0] fo_q, fo_d, blen_q, blen_d, btype_q, btype_d, ws_q, ws_d;
  logic [16:0] boff_q, boff_d, onext_q, onext_d;
  logic [15:0] ocode_q, ocode_d, olen_q, olen_d, plink_q, plink_d, plen_q, plen_d;
  logic        be_q, be_d, odone_q, odone_d, bt_q, bt_d, fin_q, fin_d;
  logic [7:0]  pres_q, pres_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0] pif_q, pif_d;
  logic [63:0] ptime_q, ptime_d;

  logic          lk_we, lk_re, lk_hit_d, lk_hit_q, rs_we;
  logic [IW-1:0] lk_waddr, lk_raddr, rs_waddr;
  logic [15:0]   lk_wdata, lk_rdata_q;
  logic [7:0]    rs_wdata, res0_q;

  always_ff @(posedge clk_i) begin
    if (lk_we) link_mem[lk_waddr] <= lk_wdata;
    if (lk_re) lk_rdata_q <= link_mem[lk_raddr];
    if (rs_we) res_mem[rs_waddr] <= rs_wdata;
    res0_q <= res_mem[IW'(0)];
  end

  always_comb begin
    logic        stop, pk_v, pk_last, fi_v, be_n;
    logic [2:0]  fst;
    logic [7:0]  pk_b;
    logic [1:0]  pk_kind;
    logic [16:0] off;
    logic [32:0] endpos;
    logic [31:0] w, len, ty, room, code32;
    logic [15:0] code, lt;
    logic [33:0] fend;
    item_t       pit, fit;

    stop = 1'b0; pk_v = 1'b0; pk_last = 1'b0; fi_v = 1'b0; fst = ST_OK;
    pk_b = '0; pk_kind = KIND_DESC;
    fo_d = fo_q; blen_d = blen_q; btype_d = btype_q; ws_d = ws_q; boff_d = boff_q;
    onext_d = onext_q; ocode_d = ocode_q; olen_d = olen_q; plink_d = plink_q;
    plen_d = plen_q; be_d = be_q; odone_d = odone_q; bt_d = bt_q; fin_d = fin_q;
    pres_d = pres_q; cnt_d = cnt_q; pif_d = pif_q; ptime_d = ptime_q;
    lk_we = 1'b0; lk_re = 1'b0; lk_hit_d = 1'b0; rs_we = 1'b0;
    lk_waddr = cnt_q[IW-1:0]; rs_waddr = cnt_q[IW-1:0]; lk_raddr = '0;
    lk_wdata = '0; rs_wdata = pres_q;
    off = boff_q; w = {byte_i, ws_q[31:8]}; be_n = be_q;
    len = blen_q; ty = btype_q; room = '0; code = '0; lt = '0; code32 = '0;
    endpos = '0; fend = '0;

    if (lk_hit_q) plink_d = lk_rdata_q;

    if (acc_i && !fin_q) begin
      ws_d = w;
      if (fo_q == 32'd3 && w != SHB_MAGIC) begin
        fi_v = 1'b1; fst = ST_BAD_MAGIC; stop = 1'b1;
      end
      if (!stop && off == 17'd3) btype_d = w;
      if (!stop && off == 17'd7) blen_d = w;
      if (!stop && off == 17'd11) begin
        if (fo_q == 32'd11) begin
          if (w == BO_MAGIC) be_n = 1'b0;
          else if (swap32(w) == BO_MAGIC) be_n = 1'b1;
          else begin
            fi_v = 1'b1; fst = ST_BAD_MAGIC; stop = 1'b1;
          end
          if (!stop) begin
            be_d = be_n;
            if (total_len_i <= 32'd12) begin
              fi_v = 1'b1; fst = ST_OK; stop = 1'b1;
            end
          end
        end
        if (!stop) begin
          ty = rd32(be_n, btype_q);
          len = rd32(be_n, blen_q);
          btype_d = ty; blen_d = len;
          endpos = {1'b0, fo_q - 32'd11} + {1'b0, len};
          if (len < 32'd12 || endpos > {1'b0, total_len_i}) begin
            fi_v = 1'b1; fst = ST_BAD_LEN; stop = 1'b1;
          end else if (len > 32'(MAX_BLOCK)) begin
            fi_v = 1'b1; fst = ST_TOO_LARGE; stop = 1'b1;
          end else if (ty == SHB_MAGIC) begin
            cnt_d = '0;
          end else if (ty == BT_IDB) begin
            lt = rd16lo(be_n, w);
            if (lt == LINK_BT) bt_d = 1'b1;
            lk_we = (cnt_q < CNT_MAX);
            lk_wdata = lt;
            pres_d = '0; onext_d = 17'd16; ocode_d = '0; olen_d = '0; odone_d = 1'b0;
          end else if (ty == BT_EPB) begin
            if (len < 32'd32) begin
              fi_v = 1'b1; fst = ST_BAD_CAP; stop = 1'b1;
            end else begin
              pif_d = rd32(be_n, w);
              plink_d = '0;
              lk_re = 1'b1;
              lk_hit_d = (pif_d < 32'(cnt_q));
              lk_raddr = pif_d[IW-1:0];
            end
          end
        end
      end

      if (!stop && off > 17'd11 && ty == BT_IDB && !odone_q) begin
        if (ocode_q == OPT_TSRES) begin
          if ({1'b0, off} == {1'b0, onext_q} + 18'd4) begin
            pres_d = byte_i; odone_d = 1'b1;
          end
        end else if ({1'b0, off} == {1'b0, onext_q} + 18'd3) begin
          if (32'(onext_q) >= len - 32'd4) begin
            odone_d = 1'b1;
          end else begin
            code = rd16lo(be_n, w);
            olen_d = rd16hi(be_n, w);
            code32 = 32'(onext_q) + 32'd4 + 32'(olen_d);
            if (code32 > len || code == '0) odone_d = 1'b1;
            else if (code == OPT_TSRES) ocode_d = OPT_TSRES;
            else onext_d = 17'((code32 + 32'd3) & ~32'd3);
          end
        end
      end

      if (!stop && off > 17'd11 && ty == BT_EPB) begin
        if (off == 17'd15) begin
          ptime_d = {rd32(be_n, w), 32'd0};
        end else if (off == 17'd19) begin
          ptime_d = {ptime_q[63:32], rd32(be_n, w)};
        end else if (off == 17'd23) begin
          code32 = rd32(be_n, w);
          room = len - 32'd32;
          if ((plink_q == LINK_BT) ? (code32 > room)
                                   : (code32 < MIN_CAP || code32 > room)) begin
            fi_v = 1'b1; fst = ST_BAD_CAP; stop = 1'b1;
          end else begin
            plen_d = code32[15:0];
            pk_v = 1'b1; pk_kind = KIND_DESC;
          end
        end else if (off >= 17'd28 && {1'b0, off} < 18'd28 + {2'b0, plen_q}) begin
          pk_v = 1'b1; pk_kind = KIND_BYTE; pk_b = byte_i;
          pk_last = ({1'b0, off} == 18'd27 + {2'b0, plen_q});
        end
      end

      if (!stop) begin
        fo_d = fo_q + 32'd1;
        if (off >= 17'd11 && 32'(off) == len - 32'd1) begin
          if (ty == BT_IDB && cnt_q < CNT_MAX) begin
            rs_we = 1'b1;
            rs_wdata = pres_d;
            cnt_d = cnt_q + CW'(1);
          end
          boff_d = '0;
          fend = {2'b0, fo_d} + 34'd12;
          if (fend >= {2'b0, total_len_i}) begin
            fi_v = 1'b1; fst = ST_OK;
          end
        end else begin
          boff_d = boff_q + 17'd1;
        end
      end
      if (fi_v) fin_d = 1'b1;
    end

    pit.kind = pk_kind;
    pit.interface_id = pif_d;
    pit.link_type = plink_q;
    pit.captured_length = plen_d;
    pit.timestamp = ptime_q;
    pit.time_resolution = (cnt_q != '0) ? res0_q : 8'd0;
    pit.payload_byte = pk_b;
    pit.last_byte = pk_last;
    pit.status = ST_OK;
    pit.bt_link = 1'b0;

    fit = '0;
    fit.kind = KIND_FINISH;
    fit.status = fst;
    fit.bt_link = bt_d;

    push_o.v0 = pk_v | fi_v;
    push_o.v1 = pk_v & fi_v;
    push_o.i0 = pk_v ? pit : fit;
    push_o.i1 = fit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fo_q <= '0; blen_q <= '0; btype_q <= '0; ws_q <= '0; boff_q <= '0;
      onext_q <= 17'd16; ocode_q <= '0; olen_q <= '0; plink_q <= '0; plen_q <= '0;
      be_q <= 1'b0; odone_q <= 1'b0; bt_q <= 1'b0; fin_q <= 1'b0; pres_q <= '0;
      cnt_q <= '0; pif_q <= '0; ptime_q <= '0; lk_hit_q <= 1'b0;
    end else begin
      fo_q <= fo_d; blen_q <= blen_d; btype_q <= btype_d; ws_q <= ws_d; boff_q <= boff_d;
      onext_q <= onext_d; ocode_q <= ocode_d; olen_q <= olen_d; plink_q <= plink_d;
      plen_q <= plen_d; be_q <= be_d; odone_q <= odone_d; bt_q <= bt_d; fin_q <= fin_d;
      pres_q <= pres_d; cnt_q <= cnt_d; pif_q <= pif_d; ptime_q <= ptime_d;
      lk_hit_q <= lk_hit_d;
    end
  end

endmodule

// ----- rtl/core/pbd_out_fifo.sv -----
module pbd_out_fifo import pbd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_o,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  item_t      buf_q [4];
  logic [1:0] wp_q, wp_d, rp_q, rp_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign space_o = (cnt_q <= 3'd2);
  assign valid_o = (cnt_q != 3'd0);
  assign item_o  = buf_q[rp_q];
  assign pop     = valid_o & ready_i;

  always_comb begin
    wp_d  = wp_q + {1'b0, push_i.v0} + {1'b0, push_i.v1};
    rp_d  = rp_q + {1'b0, pop};
    cnt_d = cnt_q + {2'b0, push_i.v0} + {2'b0, push_i.v1} - {2'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) buf_q[wp_q] <= push_i.i0;
    if (push_i.v1) buf_q[wp_q + 2'd1] <= push_i.i1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/pcapng_block_deframer_unit.sv -----
// pcapng deframer: takes one capture-file byte per cycle and emits packet
// descriptors, payload bytes and one finish record. A byte is taken every
// cycle while the four-entry output queue has room for two records; the
// interface link-type and resolution tables sit in synchronous
// memories, the link lookup for a packet completes during its header.
// After the finish record further bytes are taken and dropped until reset.
module pcapng_block_deframer_unit import pbd_pkg::*; #(
  parameter int MAX_BLOCK      = 65536,
  parameter int MAX_INTERFACES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // interface_id, link_type, captured_length, timestamp, time_resolution,
  // payload_byte, status, bt_link
  output logic [151:0] m_axis_tdata,
  output logic         m_axis_tlast,   // last_byte
  output logic [1:0]   m_axis_tuser    // kind
);

  logic [31:0] total_len_q;
  push_t       push;
  item_t       it;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) total_len_q <= '0;
    else if (cfg_we_i) total_len_q <= cfg_wdata_i;
  end

  pbd_parser #(
    .MAX_BLOCK(MAX_BLOCK),
    .MAX_INTERFACES(MAX_INTERFACES)
  ) u_parser (
    .clk_i, .rst_ni,
    .total_len_i(total_len_q),
    .acc_i(s_axis_tvalid & s_axis_tready),
    .byte_i(s_axis_tdata),
    .push_o(push)
  );

  pbd_out_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push),
    .space_o(s_axis_tready),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .item_o(it)
  );

  assign m_axis_tdata = {4'd0, it.bt_link, it.status, it.payload_byte, it.time_resolution,
                         it.timestamp, it.captured_length, it.link_type, it.interface_id};
  assign m_axis_tlast = it.last_byte;
  assign m_axis_tuser = it.kind;

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import pbd_pkg::*;

  class deframer_scoreboard;
    bit [31:0] total_len;
    bit [31:0] file_off, blk_off, blk_len, blk_type, shifter;
    bit        big_end;
    bit [31:0] opt_next, opt_code;
    bit [15:0] opt_len;
    bit        opt_done;
    bit [7:0]  pend_res;
    bit [15:0] link_tab[8];
    bit [7:0]  res_tab[8];
    int unsigned if_count;
    bit [31:0] pkt_if;
    bit [15:0] pkt_link, pkt_len;
    bit [63:0] pkt_time;
    bit        seen_bt, done;
    item_t     expected_q[$];
    int        errors;

    function new();
      opt_next = 16;
    endfunction

    function bit [31:0] flip(bit [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function bit [31:0] word(bit [31:0] w);
      return big_end ? flip(w) : w;
    endfunction

    function bit [15:0] half_lo(bit [31:0] w);
      return big_end ? {w[7:0], w[15:8]} : w[15:0];
    endfunction

    function bit [15:0] half_hi(bit [31:0] w);
      return big_end ? {w[23:16], w[31:24]} : w[31:16];
    endfunction

    function void push_packet(bit [1:0] kind, bit [7:0] pb, bit last);
      item_t it;
      it = '0;
      it.kind = kind;
      it.interface_id = pkt_if;
      it.link_type = pkt_link;
      it.captured_length = pkt_len;
      it.timestamp = pkt_time;
      it.time_resolution = if_count > 0 ? res_tab[0] : 8'd0;
      it.payload_byte = pb;
      it.last_byte = last;
      expected_q.push_back(it);
    endfunction

    function void push_finish(bit [2:0] st);
      item_t it;
      it = '0;
      it.kind = KIND_FINISH;
      it.status = st;
      it.bt_link = seen_bt;
      expected_q.push_back(it);
      done = 1;
    endfunction

    // one accepted request
    function void note_byte(bit [7:0] b);
      bit [31:0] off, len, lt, code, incl, room;
      bit [63:0] start;
      if (done) return;
      shifter = {b, shifter[31:8]};
      off = blk_off;
      if (file_off == 3 && shifter != SHB_MAGIC) begin
        push_finish(ST_BAD_MAGIC);
        return;
      end
      if (off == 3) blk_type = shifter;
      if (off == 7) blk_len = shifter;
      if (off == 11) begin
        start = {32'd0, file_off} - 64'd11;
        if (file_off == 11) begin
          if (shifter == BO_MAGIC) big_end = 0;
          else if (flip(shifter) == BO_MAGIC) big_end = 1;
          else begin
            push_finish(ST_BAD_MAGIC);
            return;
          end
          if (total_len <= 12) begin
            push_finish(ST_OK);
            return;
          end
        end
        blk_type = word(blk_type);
        blk_len = word(blk_len);
        if (blk_len < 12 || start + blk_len > {32'd0, total_len}) begin
          push_finish(ST_BAD_LEN);
          return;
        end
        if (blk_len > 65536) begin
          push_finish(ST_TOO_LARGE);
          return;
        end
        if (blk_type == SHB_MAGIC) begin
          if_count = 0;
        end else if (blk_type == BT_IDB) begin
          lt = half_lo(shifter);
          if (lt == LINK_BT) seen_bt = 1;
          if (if_count < 8) link_tab[if_count] = lt[15:0];
          pend_res = 0;
          opt_next = 16;
          opt_code = 0;
          opt_len = 0;
          opt_done = 0;
        end else if (blk_type == BT_EPB) begin
          if (blk_len < 32) begin
            push_finish(ST_BAD_CAP);
            return;
          end
          pkt_if = word(shifter);
          pkt_link = pkt_if < if_count ? link_tab[pkt_if] : 16'd0;
        end
      end
      len = blk_len;
      if (off > 11 && blk_type == BT_IDB && !opt_done) begin
        if (opt_code == OPT_TSRES) begin
          if (off == opt_next + 4) begin
            pend_res = b;
            opt_done = 1;
          end
        end else if (off == opt_next + 3) begin
          if (opt_next >= len - 4) opt_done = 1;
          else begin
            code = half_lo(shifter);
            opt_len = half_hi(shifter);
            if (opt_next + 4 + opt_len > len || code == 0) opt_done = 1;
            else if (code == OPT_TSRES) opt_code = OPT_TSRES;
            else opt_next = (opt_next + 4 + opt_len + 3) & ~32'd3;
          end
        end
      end
      if (off > 11 && blk_type == BT_EPB) begin
        if (off == 15) pkt_time = {word(shifter), 32'd0};
        else if (off == 19) pkt_time[31:0] = word(shifter);
        else if (off == 23) begin
          incl = word(shifter);
          room = len - 32;
          if (pkt_link == LINK_BT ? (incl > room) : (incl < MIN_CAP || incl > room)) begin
            push_finish(ST_BAD_CAP);
            return;
          end
          pkt_len = incl[15:0];
          push_packet(KIND_DESC, 8'd0, 1'b0);
        end else if (off >= 28 && off < 28 + pkt_len) begin
          push_packet(KIND_BYTE, b, off == 27 + pkt_len);
        end
      end
      file_off = file_off + 1;
      if (off >= 11 && off == len - 1) begin
        if (blk_type == BT_IDB && if_count < 8) begin
          res_tab[if_count] = pend_res;
          if_count++;
        end
        blk_off = 0;
        if ({32'd0, file_off} + 64'd12 >= {32'd0, total_len}) push_finish(ST_OK);
      end else begin
        blk_off = (blk_off + 1) & 32'h1FFFF;
      end
    endfunction

    function void check_result(item_t act);
      item_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result kind=%0d", act.kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (act.kind !== e.kind) begin
        $error("kind exp %0h act %0h", e.kind, act.kind); errors++;
      end
      if (act.interface_id !== e.interface_id) begin
        $error("interface_id exp %0h act %0h", e.interface_id, act.interface_id); errors++;
      end
      if (act.link_type !== e.link_type) begin
        $error("link_type exp %0h act %0h", e.link_type, act.link_type); errors++;
      end
      if (act.captured_length !== e.captured_length) begin
        $error("captured_length exp %0h act %0h", e.captured_length, act.captured_length);
        errors++;
      end
      if (act.timestamp !== e.timestamp) begin
        $error("timestamp exp %0h act %0h", e.timestamp, act.timestamp); errors++;
      end
      if (act.time_resolution !== e.time_resolution) begin
        $error("time_resolution exp %0h act %0h", e.time_resolution, act.time_resolution);
        errors++;
      end
      if (act.payload_byte !== e.payload_byte) begin
        $error("payload_byte exp %0h act %0h", e.payload_byte, act.payload_byte); errors++;
      end
      if (act.last_byte !== e.last_byte) begin
        $error("last_byte exp %0h act %0h", e.last_byte, act.last_byte); errors++;
      end
      if (act.status !== e.status) begin
        $error("status exp %0h act %0h", e.status, act.status); errors++;
      end
      if (act.bt_link !== e.bt_link) begin
        $error("bt_link exp %0h act %0h", e.bt_link, act.bt_link); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [151:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;

  deframer_scoreboard sb = new();
  bit [7:0] file_q[$];
  bit       gen_be;
  int       send_idle_pct, recv_idle_pct;
  int       hold_cycles;

  always #5 clk_i = ~clk_i;

  pcapng_block_deframer_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  always @(posedge clk_i) begin
    item_t act;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        act.kind = m_axis_tuser;
        act.interface_id = m_axis_tdata[31:0];
        act.link_type = m_axis_tdata[47:32];
        act.captured_length = m_axis_tdata[63:48];
        act.timestamp = m_axis_tdata[127:64];
        act.time_resolution = m_axis_tdata[135:128];
        act.payload_byte = m_axis_tdata[143:136];
        act.status = m_axis_tdata[146:144];
        act.bt_link = m_axis_tdata[147];
        act.last_byte = m_axis_tlast;
        sb.check_result(act);
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  function void put8(bit [7:0] v);
    file_q.push_back(v);
  endfunction

  function void put16(bit [15:0] v);
    if (gen_be) begin put8(v[15:8]); put8(v[7:0]); end
    else begin put8(v[7:0]); put8(v[15:8]); end
  endfunction

  function void put32(bit [31:0] v);
    if (gen_be) begin put16(v[31:16]); put16(v[15:0]); end
    else begin put16(v[15:0]); put16(v[31:16]); end
  endfunction

  function void add_section();
    put32(SHB_MAGIC); put32(28); put32(BO_MAGIC);
    repeat (12) put8(8'($urandom));
    put32(28);
  endfunction

  function void add_interface(bit [15:0] lt, bit want_res);
    bit [7:0] opts[$];
    int n, vlen;
    bit [15:0] code;
    bit save;
    save = gen_be;
    n = $urandom_range(3);
    for (int i = 0; i <= n; i++) begin
      code = (want_res && i == n) ? OPT_TSRES : ($urandom_range(3) == 0 ? OPT_TSRES :
             16'($urandom_range(1, 12)));
      vlen = code == OPT_TSRES ? 1 : $urandom_range(6);
      if (gen_be) begin
        opts.push_back(code[15:8]); opts.push_back(code[7:0]);
        opts.push_back(8'd0); opts.push_back(8'(vlen));
      end else begin
        opts.push_back(code[7:0]); opts.push_back(code[15:8]);
        opts.push_back(8'(vlen)); opts.push_back(8'd0);
      end
      repeat (vlen) opts.push_back(8'($urandom));
      while (opts.size() % 4) opts.push_back(8'd0);
    end
    if ($urandom_range(1)) repeat (4) opts.push_back(8'd0);
    if ($urandom_range(9) == 0) opts[2] = 8'hF0;
    put32(BT_IDB); put32(20 + opts.size());
    put16(lt); put16(16'($urandom)); put32($urandom);
    foreach (opts[i]) put8(opts[i]);
    put32(20 + opts.size());
  endfunction

  function void add_packet(int if_hint, bit bad);
    int cap, pad, extra;
    bit [31:0] cap_field;
    cap = $urandom_range(49) == 0 ? $urandom_range(13) : $urandom_range(14, 48);
    pad = (4 - cap % 4) % 4;
    extra = $urandom_range(1) * 4;
    cap_field = bad ? cap + pad + extra + 1 : cap;
    put32(BT_EPB); put32(32 + cap + pad + extra);
    put32($urandom_range(9) == 0 ? 32'hFFFFFFFF : $urandom_range(if_hint + 1));
    put32($urandom); put32($urandom); put32(cap_field); put32($urandom);
    repeat (cap) put8(8'($urandom));
    repeat (pad) put8(8'd0);
    repeat (extra) put8(8'($urandom));
    put32(32 + cap + pad + extra);
  endfunction

  function void add_other();
    int n;
    n = 4 * $urandom_range(4);
    put32($urandom_range(2, 5)); put32(12 + n);
    repeat (n) put8(8'($urandom));
    put32(12 + n);
  endfunction

  task automatic cfg_write(bit [31:0] v);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic send_byte(bit [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
  endtask

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int nif, ending, n, guard;
    bit [31:0] total;
    send_idle_pct = 10;
    recv_idle_pct = 76;
    hold_cycles = 0;
    gen_be = $urandom_range(1);
    add_section();
    add_interface(LINK_BT, 1);
    add_packet(0, 0);
    add_interface(16'h0001, 0);
    nif = 2;
    while (file_q.size() < 1550) begin
      case ($urandom_range(9))
        0: begin add_section(); nif = 0; end
        1, 2: begin add_interface($urandom_range(1) ? 16'($urandom) : 16'd1,
                                  $urandom_range(1)); nif++; end
        3: add_other();
        default: add_packet(nif, $urandom_range(40) == 0 && file_q.size() > 1400);
      endcase
    end
    total = file_q.size();
    ending = $urandom_range(3);
    case (ending)
      1: begin put32(BT_EPB); put32(8); total = file_q.size() + 64; end
      2: begin put32(BT_EPB); put32(32'h00020000); total = 32'hFFFFFFFF; end
      3: begin put32(BT_EPB); put32(28); total = file_q.size() + 64; end
      default: ;
    endcase
    repeat (40) put8(8'($urandom));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    cfg_write(32'd0);
    cfg_write(32'hFFFFFFFF);
    cfg_write(total);
    sb.total_len = total;

    n = 0;
    foreach (file_q[i]) begin
      if (n == file_q.size() / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 10;
      end else if (n == 2 * file_q.size() / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
      end
      send_byte(file_q[i]);
      n++;
    end
    s_axis_tvalid <= 0;
    guard = 0;
    while (sb.expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
    cfg_write(32'd12);
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
